// File: src/hpt_pkg.sv
// shared types and constants for the homogeneous point transform core
// no dependencies
`default_nettype none

package hpt_pkg;

    // number of configuration registers and widths
    localparam int NUM_REGS = 8;
    localparam int CFG_IW   = 8;
    localparam int CFG_DW   = 64;
    localparam int COEF_W   = 32;
    localparam int PROD_W   = 48;
    // signed width of row sums and of 2*num + h
    localparam int SW       = 52;
    // magnitude width of dividend and divisor
    localparam int MW       = 51;
    // quotient bits produced by the cell row
    localparam int QB       = 33;

    localparam logic [CFG_DW-1:0] REG_RESET [NUM_REGS] = '{
        64'd65536, 64'd0, 64'd281474976710656, 64'd0,
        64'd0, 64'd65536, 64'd0, 64'd281474976710656
    };

    typedef struct packed {
        logic signed [15:0] in_x;
        logic signed [15:0] in_y;
        logic signed [15:0] in_z;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               weight_zero;
        logic               clipped;
    } out_item_t;

    // one divider lane as it travels down the cell row
    typedef struct packed {
        logic [MW-1:0] rem;
        logic [MW-1:0] dvsr;
        logic [QB-1:0] dq;
        logic          neg;
        logic          ovf;
    } lane_t;

    // per-item control carried alongside the lanes
    typedef struct packed {
        logic valid;
        logic hz;
    } ctrl_t;

endpackage

`default_nettype wire

// File: src/homogeneous_point_transform_core.sv
// top level: configuration registers, front end, row of divider cells, output stage
// depends on hpt_pkg, hpt_front, hpt_cell
//
//  channel   | signals                                    | handshake
//  ----------+--------------------------------------------+--------------------------
//  input     | start, busy, item                          | taken when start && !busy
//  result    | result_valid, result                       | one-cycle strobe
//  config    | cfg_valid, cfg_ready, cfg_index, cfg_data  | valid && ready
//
// one item per clock; busy stays low.
// the pipe is 4 front-end stages, 33 division cells (one quotient
// bit each, three lanes side by side) and the output register.
// reset clears the valid pipe and loads the identity matrix.
// the receiver cannot stall, so nothing holds the pipe.
`default_nettype none

module homogeneous_point_transform_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output      logic                           busy,
    input  wire hpt_pkg::in_item_t              item,
    output      logic                           result_valid,
    output      hpt_pkg::out_item_t             result,
    input  wire logic                           cfg_valid,
    output      logic                           cfg_ready,
    input  wire logic [hpt_pkg::CFG_IW-1:0]     cfg_index,
    input  wire logic [hpt_pkg::CFG_DW-1:0]     cfg_data
);

    logic [hpt_pkg::CFG_DW-1:0]              cfg_reg [hpt_pkg::NUM_REGS];
    logic [15:0][hpt_pkg::COEF_W-1:0]        coef;
    hpt_pkg::ctrl_t                          front_ctrl;
    hpt_pkg::lane_t [2:0]                    chain [hpt_pkg::QB+1];
    logic [hpt_pkg::QB-1:0]                  vld_reg;
    logic [hpt_pkg::QB-1:0]                  hz_reg;
    hpt_pkg::out_item_t                      res_next;
    hpt_pkg::out_item_t                      res_reg;
    logic                                    res_vld_reg;
    logic signed [31:0]                      q [3];
    logic [2:0]                              clip;
    logic [hpt_pkg::QB-1:0]                  qm;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // configuration registers, out-of-range index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < hpt_pkg::NUM_REGS; i++)
            begin
                cfg_reg[i] <= hpt_pkg::REG_RESET[i];
            end
        end
        else if (cfg_valid && cfg_ready && (cfg_index < hpt_pkg::CFG_IW'(hpt_pkg::NUM_REGS)))
        begin
            cfg_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    // unpack coefficients, row-major
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                coef[4*r+c] = cfg_reg[2*r + c/2][(c%2)*32 +: 32];
            end
        end
    end

    hpt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .item     (item),
        .coef     (coef),
        .ctrl     (front_ctrl),
        .lanes    (chain[0])
    );

    // row of division cells, three lanes per step
    for (genvar k = 0; k < hpt_pkg::QB; k++)
    begin : g_step
        for (genvar l = 0; l < 3; l++)
        begin : g_lane
            hpt_cell u_cell (
                .clk      (clk),
                .lane_in  (chain[k][l]),
                .lane_out (chain[k+1][l])
            );
        end
    end

    // control travels with the cells
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[hpt_pkg::QB-2:0], front_ctrl.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        hz_reg <= {hz_reg[hpt_pkg::QB-2:0], front_ctrl.hz};
    end

    // sign, saturation and zero weight
    always_comb
    begin
        qm = '0;
        for (int l = 0; l < 3; l++)
        begin
            qm = chain[hpt_pkg::QB][l].dq;
            if (chain[hpt_pkg::QB][l].neg)
            begin
                clip[l] = chain[hpt_pkg::QB][l].ovf || (qm > 33'h080000000);
                q[l]    = clip[l] ? 32'sh80000000 : -$signed(qm[31:0]);
            end
            else
            begin
                clip[l] = chain[hpt_pkg::QB][l].ovf || (qm > 33'h07fffffff);
                q[l]    = clip[l] ? 32'sh7fffffff : $signed(qm[31:0]);
            end
        end
        if (hz_reg[hpt_pkg::QB-1])
        begin
            res_next.out_x       = '0;
            res_next.out_y       = '0;
            res_next.out_z       = '0;
            res_next.weight_zero = 1'b1;
            res_next.clipped     = 1'b0;
        end
        else
        begin
            res_next.out_x       = q[0];
            res_next.out_y       = q[1];
            res_next.out_z       = q[2];
            res_next.weight_zero = 1'b0;
            res_next.clipped     = |clip;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else
        begin
            res_vld_reg <= vld_reg[hpt_pkg::QB-1];
        end
    end

    assign result_valid = res_vld_reg;
    assign result       = res_reg;

endmodule

`default_nettype wire

// File: src/hpt_cell.sv
// one restoring-division cell: one quotient bit for one lane per cycle
// depends on hpt_pkg
`default_nettype none

module hpt_cell (
    input  wire logic          clk,
    input  wire hpt_pkg::lane_t lane_in,
    output hpt_pkg::lane_t      lane_out
);

    logic [hpt_pkg::MW:0]   bring;
    logic [hpt_pkg::MW:0]   diff;
    logic                   qbit;
    hpt_pkg::lane_t         lane_next;
    hpt_pkg::lane_t         lane_reg;

    // bring down the next dividend bit and try the subtraction
    always_comb
    begin
        bring = {lane_in.rem, lane_in.dq[hpt_pkg::QB-1]};
        diff  = bring - {1'b0, lane_in.dvsr};
        qbit  = (bring >= {1'b0, lane_in.dvsr});
        lane_next      = lane_in;
        lane_next.rem  = qbit ? diff[hpt_pkg::MW-1:0] : bring[hpt_pkg::MW-1:0];
        lane_next.dq   = {lane_in.dq[hpt_pkg::QB-2:0], qbit};
    end

    // payload register, no reset needed
    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
    end

    assign lane_out = lane_reg;

endmodule

`default_nettype wire

// File: src/hpt_front.sv
// front end: products, row sums, dividend/divisor magnitudes, overflow check
// depends on hpt_pkg
`default_nettype none

module hpt_front (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    input  wire hpt_pkg::in_item_t                    item,
    input  wire logic [15:0][hpt_pkg::COEF_W-1:0]     coef,
    output hpt_pkg::ctrl_t                            ctrl,
    output hpt_pkg::lane_t [2:0]                      lanes
);

    logic signed [15:0]              pt [3];
    logic signed [hpt_pkg::PROD_W-1:0] prod_reg [4][3];
    logic signed [hpt_pkg::COEF_W-1:0] cst_reg  [4];
    logic signed [hpt_pkg::SW-1:0]   sum_next [4];
    logic signed [hpt_pkg::SW-1:0]   sum_reg  [4];
    logic signed [hpt_pkg::SW-1:0]   n_s [3];
    logic signed [hpt_pkg::SW-1:0]   d_s;
    logic signed [hpt_pkg::SW-1:0]   n_abs [3];
    logic signed [hpt_pkg::SW-1:0]   d_abs;
    logic [hpt_pkg::MW-1:0]          nmag_reg [3];
    logic [hpt_pkg::MW-1:0]          dmag_reg;
    logic [2:0]                      neg_reg;
    logic [hpt_pkg::MW-1:0]          hi [3];
    hpt_pkg::lane_t [2:0]            lane_next;
    hpt_pkg::lane_t [2:0]            lane_reg;
    logic [3:0]                      vld_reg;
    logic                            hz_reg;
    logic                            hz4_reg;

    assign pt[0] = item.in_x;
    assign pt[1] = item.in_y;
    assign pt[2] = item.in_z;

    // stage 1: coefficient times coordinate
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_reg[r][c] <= $signed(coef[4*r+c]) * pt[c];
            end
            cst_reg[r] <= $signed(coef[4*r+3]);
        end
    end

    // stage 2: row sums and weight
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            sum_next[r] = hpt_pkg::SW'(prod_reg[r][0]) + hpt_pkg::SW'(prod_reg[r][1])
                        + hpt_pkg::SW'(prod_reg[r][2]) + hpt_pkg::SW'(cst_reg[r]);
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    // stage 3: dividend 2*num+h and divisor 2*h as sign and magnitude
    always_comb
    begin
        d_s   = (sum_reg[3] <<< 1);
        d_abs = d_s[hpt_pkg::SW-1] ? -d_s : d_s;
        for (int r = 0; r < 3; r++)
        begin
            n_s[r]   = (sum_reg[r] <<< 1) + sum_reg[3];
            n_abs[r] = n_s[r][hpt_pkg::SW-1] ? -n_s[r] : n_s[r];
        end
    end

    always_ff @(posedge clk)
    begin
        dmag_reg <= d_abs[hpt_pkg::MW-1:0];
        hz_reg   <= (sum_reg[3] == '0);
        for (int r = 0; r < 3; r++)
        begin
            nmag_reg[r] <= n_abs[r][hpt_pkg::MW-1:0];
            neg_reg[r]  <= n_s[r][hpt_pkg::SW-1] ^ sum_reg[3][hpt_pkg::SW-1];
        end
    end

    // stage 4: quotient too large for the cell row, and lane setup
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            hi[r] = nmag_reg[r] >> hpt_pkg::QB;
            lane_next[r].rem  = hi[r];
            lane_next[r].dvsr = dmag_reg;
            lane_next[r].dq   = nmag_reg[r][hpt_pkg::QB-1:0];
            lane_next[r].neg  = neg_reg[r];
            lane_next[r].ovf  = (hi[r] >= dmag_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
        hz4_reg  <= hz_reg;
    end

    // valid pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    assign lanes      = lane_reg;
    assign ctrl.valid = vld_reg[3];
    assign ctrl.hz    = hz4_reg;

endmodule

`default_nettype wire

// File: bench/homogeneous_point_transform_core_test.sv
// testbench for the homogeneous point transform core: directed and random points
// through several matrices, checked against a built-in projective predictor
// depends on hpt_pkg and homogeneous_point_transform_core
`default_nettype none

module homogeneous_point_transform_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    // coefficient register indexes
    typedef enum int {
        R0_XY = 0, R0_ZT = 1, R1_XY = 2, R1_ZT = 3,
        R2_XY = 4, R2_ZT = 5, R3_XY = 6, R3_ZW = 7
    } coef_reg_e;

    localparam int  DRAIN_CYCLES = 60;
    localparam longint CYCLE_LIMIT = 400000;

    // queue of expected mapped points with a copy of the coefficient registers
    class point_scoreboard;
        logic [63:0]         coef_regs [hpt_pkg::NUM_REGS];
        hpt_pkg::out_item_t  pending [$];
        int                  errors;
        int                  checked;
        int                  clip_seen;
        int                  zero_seen;

        function new();
            for (int i = 0; i < hpt_pkg::NUM_REGS; i++)
                coef_regs[i] = hpt_pkg::REG_RESET[i];
            errors = 0;
            checked = 0;
            clip_seen = 0;
            zero_seen = 0;
        endfunction

        function void write_reg(int idx, logic [63:0] val);
            if (idx < hpt_pkg::NUM_REGS)
                coef_regs[idx] = val;
        endfunction

        function longint coef(int r, int c);
            logic [63:0] w;
            logic signed [31:0] half;
            w = coef_regs[r * 2 + c / 2];
            half = (c % 2) ? w[63:32] : w[31:0];
            return longint'(half);
        endfunction

        function longint row_total(int r, longint x, longint y, longint z);
            return coef(r, 0) * x + coef(r, 1) * y + coef(r, 2) * z + coef(r, 3);
        endfunction

        // predict the mapped point for one accepted item
        function void note_point(hpt_pkg::in_item_t it);
            hpt_pkg::out_item_t exp_pt;
            longint x, y, z, h, num, q;
            logic signed [31:0] coord [3];
            x = longint'(it.in_x);
            y = longint'(it.in_y);
            z = longint'(it.in_z);
            h = row_total(3, x, y, z);
            exp_pt = '0;
            if (h == 0)
            begin
                exp_pt.weight_zero = 1'b1;
            end
            else
            begin
                for (int r = 0; r < 3; r++)
                begin
                    num = row_total(r, x, y, z);
                    q = (2 * num + h) / (2 * h);
                    if (q > 64'sd2147483647)
                    begin
                        q = 64'sd2147483647;
                        exp_pt.clipped = 1'b1;
                    end
                    else if (q < -64'sd2147483648)
                    begin
                        q = -64'sd2147483648;
                        exp_pt.clipped = 1'b1;
                    end
                    coord[r] = q[31:0];
                end
                exp_pt.out_x = coord[0];
                exp_pt.out_y = coord[1];
                exp_pt.out_z = coord[2];
            end
            pending.push_back(exp_pt);
        endfunction

        function void check_point(hpt_pkg::out_item_t got);
            hpt_pkg::out_item_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result x=%0d y=%0d z=%0d", got.out_x, got.out_y, got.out_z);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (e.clipped) clip_seen++;
            if (e.weight_zero) zero_seen++;
            if (got.out_x !== e.out_x)
            begin
                $error("out_x expected %0d actual %0d", e.out_x, got.out_x);
                errors++;
            end
            if (got.out_y !== e.out_y)
            begin
                $error("out_y expected %0d actual %0d", e.out_y, got.out_y);
                errors++;
            end
            if (got.out_z !== e.out_z)
            begin
                $error("out_z expected %0d actual %0d", e.out_z, got.out_z);
                errors++;
            end
            if (got.weight_zero !== e.weight_zero)
            begin
                $error("weight_zero expected %0b actual %0b", e.weight_zero, got.weight_zero);
                errors++;
            end
            if (got.clipped !== e.clipped)
            begin
                $error("clipped expected %0b actual %0b", e.clipped, got.clipped);
                errors++;
            end
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    hpt_pkg::in_item_t           item;
    logic                        result_valid;
    hpt_pkg::out_item_t          result;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [hpt_pkg::CFG_IW-1:0]  cfg_index;
    logic [hpt_pkg::CFG_DW-1:0]  cfg_data;

    point_scoreboard sb;
    int     send_idle_pct;
    longint cycle_count;

    homogeneous_point_transform_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // result monitor and run limit
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_point(result);
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // send one item, with random idle cycles before it
    task automatic send_point(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        hpt_pkg::in_item_t it;
        it.in_x = x;
        it.in_y = y;
        it.in_z = z;
        while ($urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            item <= hpt_pkg::in_item_t'($urandom);
            @(posedge clk);
        end
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_point(it);
    endtask

    // idle the input and wait for every expected item plus the pipe latency
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one register write, then one idle cycle on the channel
    task automatic write_reg(int idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx[hpt_pkg::CFG_IW-1:0];
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // pack two Q16.16 coefficients into one register value
    function automatic logic [63:0] pair(logic [31:0] lo, logic [31:0] hi);
        return {hi, lo};
    endfunction

    function automatic logic [31:0] rand_coef(int mode);
        case (mode)
            0: return 32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
            1: return $urandom;
            2: return ($urandom_range(1)) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 64)) - 32);
        endcase
    endfunction

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(9))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($signed($urandom_range(0, 16)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    // load a random matrix; mode picks the coefficient spread
    task automatic load_matrix(int mode);
        for (int r = 0; r < hpt_pkg::NUM_REGS; r++)
            write_reg(r, pair(rand_coef(mode), rand_coef(mode)));
        // in mode 0, set the weight row's z term small and w near one so results mostly stay in range
        if (mode == 0)
            write_reg(R3_ZW, pair(rand_coef(3), 32'(65536 + $urandom_range(0, 4096))));
    endtask

    task automatic random_points(int count);
        for (int i = 0; i < count; i++)
            send_point(rand_coord(), rand_coord(), rand_coord());
    endtask

    initial
    begin
        sb = new();
        cycle_count = 0;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 15;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity matrix after reset, coordinate extremes
        send_point(16'h7fff, 16'h8000, 16'h0000);
        send_point(16'h8000, 16'h7fff, 16'hffff);
        send_point(16'h0001, 16'hffff, 16'h7fff);
        send_point(16'h5555, 16'haaaa, 16'h8000);
        drain();

        // halving in row 0 tests rounding of halves both signs, out-of-range index ignored
        write_reg(R0_XY, pair(32'h00008000, 32'h0));
        write_reg(8, 64'hffff_ffff_ffff_ffff);
        write_reg(255, 64'h0);
        send_point(16'h0001, 16'h0, 16'h0);
        send_point(16'hffff, 16'h0, 16'h0);
        send_point(16'h0003, 16'h0, 16'h0);
        send_point(16'hfffd, 16'h0, 16'h0);
        drain();

        // zero weight: weight depends on x only
        write_reg(R3_XY, pair(32'h00010000, 32'h0));
        write_reg(R3_ZW, pair(32'h0, 32'h0));
        send_point(16'h0000, 16'h1234, 16'h8000);
        send_point(16'h0001, 16'h1234, 16'h8000);
        send_point(16'hffff, 16'h7fff, 16'h7fff);
        drain();

        // saturation: tiny weight, huge numerators of both signs
        write_reg(R0_XY, pair(32'h7fffffff, 32'h7fffffff));
        write_reg(R0_ZT, pair(32'h7fffffff, 32'h7fffffff));
        write_reg(R1_XY, pair(32'h80000000, 32'h80000000));
        write_reg(R1_ZT, pair(32'h80000000, 32'h80000000));
        write_reg(R2_XY, pair(32'hffffffff, 32'h00000001));
        write_reg(R2_ZT, pair(32'h7fffffff, 32'h80000000));
        write_reg(R3_XY, pair(32'h0, 32'h0));
        write_reg(R3_ZW, pair(32'h0, 32'h00000001));
        send_point(16'h7fff, 16'h7fff, 16'h7fff);
        send_point(16'h8000, 16'h8000, 16'h8000);
        send_point(16'h0000, 16'h0000, 16'h0000);
        drain();
        write_reg(R3_ZW, pair(32'h0, 32'hffffffff));
        send_point(16'h7fff, 16'h8000, 16'h7fff);
        send_point(16'h8000, 16'h7fff, 16'h0001);
        drain();

        // random matrices, sender idles 15 percent
        for (int ph = 0; ph < 8; ph++)
        begin
            load_matrix(ph % 4);
            random_points(80);
            drain();
        end

        // sender idles 82 percent
        send_idle_pct = 82;
        for (int ph = 0; ph < 4; ph++)
        begin
            load_matrix(ph % 4);
            random_points(80);
            drain();
        end

        // back to back
        send_idle_pct = 0;
        for (int ph = 0; ph < 8; ph++)
        begin
            load_matrix(ph % 4);
            random_points(120);
            drain();
        end

        drain();
        $display("checked %0d mapped points over many matrices", sb.checked);
        $display("  %0d zero-weight and %0d saturated results", sb.zero_seen, sb.clip_seen);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
src/hpt_pkg.sv
src/hpt_cell.sv
src/hpt_front.sv
src/homogeneous_point_transform_core.sv
bench/homogeneous_point_transform_core_test.sv
